@@ hdl/asgr_pkg.sv @@
// ----------------------------------------------------------------------------
// asgr_pkg
// Types, constants and the SGR code decoder shared by the attribute parser.
// ----------------------------------------------------------------------------
package asgr_pkg;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_USE_ANSI   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEFAULT_FG = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEFAULT_BG = 2'd2;

   // Register reset values.
   localparam logic       RST_USE_ANSI   = 1'b1;
   localparam logic [3:0] RST_DEFAULT_FG = 4'd7;
   localparam logic [3:0] RST_DEFAULT_BG = 4'd0;

   // Operation codes of an input item.
   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Byte values.
   localparam logic [7:0] BYTE_ESC   = 8'd27;
   localparam logic [7:0] BYTE_FINAL = 8'h6D;   // 'm'
   localparam logic [7:0] BYTE_ZERO  = 8'd48;   // '0'
   localparam logic [7:0] BYTE_NINE  = 8'd57;   // '9'
   localparam logic [7:0] BYTE_UC_A  = 8'h41;
   localparam logic [7:0] BYTE_UC_Z  = 8'h5A;
   localparam logic [7:0] BYTE_LC_A  = 8'h61;
   localparam logic [7:0] BYTE_LC_Z  = 8'h7A;
   localparam logic [7:0] ACC_MAX    = 8'd255;

   // SGR codes.
   localparam logic [7:0] SGR_RESET       = 8'd0;
   localparam logic [7:0] SGR_BRIGHT      = 8'd1;
   localparam logic [7:0] SGR_DIM         = 8'd2;
   localparam logic [7:0] SGR_ITALIC      = 8'd3;
   localparam logic [7:0] SGR_UNDERLINE   = 8'd4;
   localparam logic [7:0] SGR_BLINK_SLOW  = 8'd5;
   localparam logic [7:0] SGR_BLINK_FAST  = 8'd6;
   localparam logic [7:0] SGR_NEGATIVE    = 8'd7;
   localparam logic [7:0] SGR_INVISIBLE   = 8'd8;
   localparam logic [7:0] SGR_STRIKE      = 8'd9;
   localparam logic [7:0] SGR_ITALIC_ALT  = 8'd20;
   localparam logic [7:0] SGR_UNDER_ALT   = 8'd21;
   localparam logic [7:0] SGR_NORMAL      = 8'd22;
   localparam logic [7:0] SGR_ITALIC_OFF  = 8'd23;
   localparam logic [7:0] SGR_UNDER_OFF   = 8'd24;
   localparam logic [7:0] SGR_BLINK_OFF   = 8'd25;
   localparam logic [7:0] SGR_NEG_OFF     = 8'd27;
   localparam logic [7:0] SGR_INVIS_OFF   = 8'd28;
   localparam logic [7:0] SGR_STRIKE_OFF  = 8'd29;
   localparam logic [7:0] SGR_FG_FIRST    = 8'd30;
   localparam logic [7:0] SGR_FG_LAST     = 8'd37;
   localparam logic [7:0] SGR_FG_DEFAULT  = 8'd39;
   localparam logic [7:0] SGR_BG_FIRST    = 8'd40;
   localparam logic [7:0] SGR_BG_LAST     = 8'd47;
   localparam logic [7:0] SGR_BG_DEFAULT  = 8'd49;

   // Attribute bit positions.
   localparam int unsigned ATTR_ITALIC    = 0;
   localparam int unsigned ATTR_UNDERLINE = 1;
   localparam int unsigned ATTR_STRIKE    = 2;
   localparam int unsigned ATTR_BLINK     = 3;
   localparam int unsigned ATTR_NEGATIVE  = 4;
   localparam int unsigned ATTR_INVISIBLE = 5;
   localparam int unsigned ATTR_WIDTH     = 6;

   // One set of display attributes (live or shadow copy).
   typedef struct packed {
      logic [3:0]            fg;
      logic [3:0]            bg;
      logic                  bright;
      logic [ATTR_WIDTH-1:0] attr;
   } attr_set_type;

   // Applies one SGR code to an attribute set.
   function automatic attr_set_type apply_code(
      input logic [7:0]   code,
      input attr_set_type cur,
      input logic [3:0]   dflt_fg,
      input logic [3:0]   dflt_bg
   );
      attr_set_type nxt;
      logic [7:0]   offset;
      nxt    = cur;
      offset = 8'd0;
      if (code >= SGR_FG_FIRST && code <= SGR_FG_LAST) begin
         offset = code - SGR_FG_FIRST;
         nxt.fg = {cur.bright, offset[2:0]};
      end else if (code >= SGR_BG_FIRST && code <= SGR_BG_LAST) begin
         offset = code - SGR_BG_FIRST;
         nxt.bg = {1'b0, offset[2:0]};
      end else begin
         unique case (code)
            SGR_RESET: begin
               nxt.fg     = dflt_fg;
               nxt.bg     = dflt_bg;
               nxt.bright = 1'b0;
               nxt.attr   = '0;
            end
            // Bright moves a low foreground index into the upper half.
            SGR_BRIGHT: begin
               nxt.bright = 1'b1;
               nxt.fg[3]  = 1'b1;
            end
            SGR_DIM, SGR_NORMAL: begin
               nxt.bright = 1'b0;
               nxt.fg[3]  = 1'b0;
            end
            SGR_ITALIC, SGR_ITALIC_ALT:        nxt.attr[ATTR_ITALIC]    = 1'b1;
            SGR_UNDERLINE, SGR_UNDER_ALT:      nxt.attr[ATTR_UNDERLINE] = 1'b1;
            SGR_STRIKE:                        nxt.attr[ATTR_STRIKE]    = 1'b1;
            SGR_BLINK_SLOW, SGR_BLINK_FAST:    nxt.attr[ATTR_BLINK]     = 1'b1;
            SGR_NEGATIVE:                      nxt.attr[ATTR_NEGATIVE]  = 1'b1;
            SGR_INVISIBLE:                     nxt.attr[ATTR_INVISIBLE] = 1'b1;
            SGR_ITALIC_OFF:                    nxt.attr[ATTR_ITALIC]    = 1'b0;
            SGR_UNDER_OFF:                     nxt.attr[ATTR_UNDERLINE] = 1'b0;
            SGR_STRIKE_OFF:                    nxt.attr[ATTR_STRIKE]    = 1'b0;
            SGR_BLINK_OFF:                     nxt.attr[ATTR_BLINK]     = 1'b0;
            SGR_NEG_OFF:                       nxt.attr[ATTR_NEGATIVE]  = 1'b0;
            SGR_INVIS_OFF:                     nxt.attr[ATTR_INVISIBLE] = 1'b0;
            SGR_FG_DEFAULT: begin
               nxt.fg = {dflt_fg[3] | cur.bright, dflt_fg[2:0]};
            end
            SGR_BG_DEFAULT:                    nxt.bg = dflt_bg;
            default: begin
               nxt = cur;
            end
         endcase
      end
      return nxt;
   endfunction

endpackage

@@ hdl/ansi_sgr_attribute_parser_top.sv @@
// An accepted item is held in the input register, then a plain byte's
// result in the result register. Throughput: one item per cycle while
// results are taken; a result left waiting holds the input register.
// Reset: synchronous, active high; clears the escape state, restores the
// registers to use_ansi = 1, default_fg = 7, default_bg = 0 and the live
// and shadow attributes to those defaults.
// ----------------------------------------------------------------------------
// ansi_sgr_attribute_parser_top
// Strips escape sequences from a terminal byte stream and tags each plain
// byte with the current SGR palette indices and attribute bits.
// ----------------------------------------------------------------------------
module ansi_sgr_attribute_parser_top (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [7:0]                          req_in_byte,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_text_byte,
   output logic [3:0]                          rsp_fg_index,
   output logic [3:0]                          rsp_bg_index,
   output logic [5:0]                          rsp_attr_bits,
   // Configuration port
   input  logic                                csr_we,
   input  logic [asgr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [asgr_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import asgr_pkg::*;

   // Configuration registers.
   logic       use_ansi_ff;
   logic [3:0] default_fg_ff;
   logic [3:0] default_bg_ff;

   // Input register.
   logic       stage_vld_ff;
   logic       stage_op_ff;
   logic [7:0] stage_byte_ff;

   // Parser state.
   logic         in_escape_ff, in_escape_in;
   logic         in_number_ff, in_number_in;
   logic [7:0]   number_acc_ff, number_acc_in;
   logic         saw_code_ff, saw_code_in;
   attr_set_type live_ff, live_in;
   attr_set_type shadow_ff, shadow_in;

   // Result register.
   logic         out_vld_ff, out_vld_in;
   logic [7:0]   out_byte_ff;
   attr_set_type out_attr_ff;

   // Combinational helpers.
   logic         fire;
   logic         emit;
   logic         is_digit;
   logic         is_letter;
   logic         commit;
   logic         do_apply;
   logic [7:0]   apply_val;
   attr_set_type applied;
   attr_set_type defaults;
   logic [7:0]   digit;
   logic [11:0]  acc_base;
   logic [11:0]  acc_sum;

   // The stage moves into the result register when that register is free or drained.
   assign fire      = stage_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !stage_vld_ff || fire;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         use_ansi_ff   <= RST_USE_ANSI;
         default_fg_ff <= RST_DEFAULT_FG;
         default_bg_ff <= RST_DEFAULT_BG;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_USE_ANSI:   use_ansi_ff   <= csr_wdata[0];
            CSR_DEFAULT_FG: default_fg_ff <= csr_wdata[3:0];
            CSR_DEFAULT_BG: default_bg_ff <= csr_wdata[3:0];
            default: begin
               use_ansi_ff <= use_ansi_ff;
            end
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else if (req_ready) begin
         stage_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_op_ff   <= req_op;
         stage_byte_ff <= req_in_byte;
      end
   end

   // Byte classification and the saturating decimal accumulator.
   assign is_digit  = (stage_byte_ff >= BYTE_ZERO) && (stage_byte_ff <= BYTE_NINE);
   assign is_letter = ((stage_byte_ff >= BYTE_UC_A) && (stage_byte_ff <= BYTE_UC_Z)) ||
                      ((stage_byte_ff >= BYTE_LC_A) && (stage_byte_ff <= BYTE_LC_Z));
   assign digit     = stage_byte_ff - BYTE_ZERO;
   assign acc_base  = in_number_ff ? {4'd0, number_acc_ff} : 12'd0;
   assign acc_sum   = {acc_base[8:0], 3'b000} + {acc_base[10:0], 1'b0} + {4'd0, digit};

   // A finished parameter is applied; a bare final 'm' acts as code 0.
   // Both never happen together, so one decoder serves.
   assign commit    = is_letter && (stage_byte_ff == BYTE_FINAL) && use_ansi_ff;
   assign do_apply  = in_number_ff || (commit && !saw_code_ff);
   assign apply_val = in_number_ff ? number_acc_ff : SGR_RESET;
   assign applied   = apply_code(apply_val, shadow_ff, default_fg_ff, default_bg_ff);

   assign defaults  = '{fg: default_fg_ff, bg: default_bg_ff, bright: 1'b0, attr: '0};

   assign emit = fire && (stage_op_ff == OP_BYTE) && !in_escape_ff &&
                 (stage_byte_ff != BYTE_ESC);

   // Next parser state for the item in the input register.
   always_comb begin
      in_escape_in  = in_escape_ff;
      in_number_in  = in_number_ff;
      number_acc_in = number_acc_ff;
      saw_code_in   = saw_code_ff;
      live_in       = live_ff;
      shadow_in     = shadow_ff;
      if (fire) begin
         priority if (stage_op_ff == OP_FLUSH) begin
            in_escape_in  = 1'b0;
            in_number_in  = 1'b0;
            number_acc_in = 8'd0;
            saw_code_in   = 1'b0;
            live_in       = defaults;
            shadow_in     = defaults;
         end else if (!in_escape_ff) begin
            // An ESC opens a sequence on a fresh copy of the live attributes.
            if (stage_byte_ff == BYTE_ESC) begin
               in_escape_in  = 1'b1;
               in_number_in  = 1'b0;
               number_acc_in = 8'd0;
               saw_code_in   = 1'b0;
               shadow_in     = live_ff;
            end
         end else if (is_digit) begin
            number_acc_in = (acc_sum > {4'd0, ACC_MAX}) ? ACC_MAX : acc_sum[7:0];
            in_number_in  = 1'b1;
         end else begin
            if (do_apply) begin
               shadow_in = applied;
            end
            if (in_number_ff) begin
               saw_code_in   = 1'b1;
               in_number_in  = 1'b0;
               number_acc_in = 8'd0;
            end
            // A letter ends the sequence; only a final 'm' with use_ansi set makes it live.
            if (is_letter) begin
               if (commit) begin
                  live_in = do_apply ? applied : shadow_ff;
               end
               in_escape_in  = 1'b0;
               in_number_in  = 1'b0;
               number_acc_in = 8'd0;
               saw_code_in   = 1'b0;
            end
         end
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_escape_ff  <= 1'b0;
         in_number_ff  <= 1'b0;
         number_acc_ff <= 8'd0;
         saw_code_ff   <= 1'b0;
         live_ff       <= '{fg: RST_DEFAULT_FG, bg: RST_DEFAULT_BG, bright: 1'b0, attr: '0};
         shadow_ff     <= '{fg: RST_DEFAULT_FG, bg: RST_DEFAULT_BG, bright: 1'b0, attr: '0};
      end else begin
         in_escape_ff  <= in_escape_in;
         in_number_ff  <= in_number_in;
         number_acc_ff <= number_acc_in;
         saw_code_ff   <= saw_code_in;
         live_ff       <= live_in;
         shadow_ff     <= shadow_in;
      end
   end

   // Result register: holds until taken, refilled in the same cycle it drains.
   always_comb begin
      out_vld_in = out_vld_ff;
      if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
      if (emit) begin
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff <= stage_byte_ff;
         out_attr_ff <= live_ff;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_text_byte = out_byte_ff;
   assign rsp_fg_index  = out_attr_ff.fg;
   assign rsp_bg_index  = out_attr_ff.bg;
   assign rsp_attr_bits = out_attr_ff.attr;

endmodule

@@ tb/asgr_stream_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// asgr_stream_checker
// Watches the byte, result and register ports of the SGR attribute parser.
// It keeps its own copy of the parser state and predicts the styled byte
// that each accepted plain byte must produce. Each accepted result is then
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module asgr_stream_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_op,
   input  logic [7:0]                           req_in_byte,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [7:0]                           rsp_text_byte,
   input  logic [3:0]                           rsp_fg_index,
   input  logic [3:0]                           rsp_bg_index,
   input  logic [5:0]                           rsp_attr_bits,
   input  logic                                 csr_we,
   input  logic [asgr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [asgr_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                                 run_done,
   output int unsigned                          fail_count,
   output int unsigned                          pending,
   output int unsigned                          checked_count
);
   import asgr_pkg::*;

   // One plain byte together with the style it must be shown in.
   typedef struct packed {
      logic [7:0] text;
      logic [3:0] fg;
      logic [3:0] bg;
      logic [5:0] attr;
   } styled_byte_type;

   styled_byte_type styled_due[$];

   // Register copies.
   logic       ansi_on;
   logic [3:0] dflt_fg;
   logic [3:0] dflt_bg;

   // Escape parsing state and the two attribute copies.
   logic         in_esc;
   logic         num_active;
   logic         code_seen;
   logic [7:0]   num_acc;
   attr_set_type live_set;
   attr_set_type shadow_set;
   logic         leftovers_done;

   function automatic void mark_failure(input string what);
      fail_count++;
      if (fail_count <= 10) begin
         $display("MISMATCH at %0t: %s", $realtime, what);
      end
   endfunction

   function automatic void leave_escape();
      in_esc     = 1'b0;
      num_active = 1'b0;
      num_acc    = 8'd0;
      code_seen  = 1'b0;
   endfunction

   function automatic void restore_defaults();
      live_set.fg     = dflt_fg;
      live_set.bg     = dflt_bg;
      live_set.bright = 1'b0;
      live_set.attr   = '0;
      shadow_set      = live_set;
   endfunction

   // Applies one finished parameter to the shadow attributes.
   function automatic void stage_sgr_code(input logic [7:0] code);
      if (code >= SGR_FG_FIRST && code <= SGR_FG_LAST) begin
         shadow_set.fg = 4'(code - SGR_FG_FIRST);
         if (shadow_set.bright) begin
            shadow_set.fg = shadow_set.fg + 4'd8;
         end
      end else if (code >= SGR_BG_FIRST && code <= SGR_BG_LAST) begin
         shadow_set.bg = 4'(code - SGR_BG_FIRST);
      end else begin
         case (code)
            SGR_RESET: begin
               shadow_set.fg     = dflt_fg;
               shadow_set.bg     = dflt_bg;
               shadow_set.bright = 1'b0;
               shadow_set.attr   = '0;
            end
            SGR_BRIGHT: begin
               shadow_set.bright = 1'b1;
               if (shadow_set.fg < 4'd8) begin
                  shadow_set.fg = shadow_set.fg + 4'd8;
               end
            end
            SGR_DIM, SGR_NORMAL: begin
               shadow_set.bright = 1'b0;
               if (shadow_set.fg >= 4'd8) begin
                  shadow_set.fg = shadow_set.fg - 4'd8;
               end
            end
            SGR_ITALIC, SGR_ITALIC_ALT:     shadow_set.attr[ATTR_ITALIC]    = 1'b1;
            SGR_UNDERLINE, SGR_UNDER_ALT:   shadow_set.attr[ATTR_UNDERLINE] = 1'b1;
            SGR_STRIKE:                     shadow_set.attr[ATTR_STRIKE]    = 1'b1;
            SGR_BLINK_SLOW, SGR_BLINK_FAST: shadow_set.attr[ATTR_BLINK]     = 1'b1;
            SGR_NEGATIVE:                   shadow_set.attr[ATTR_NEGATIVE]  = 1'b1;
            SGR_INVISIBLE:                  shadow_set.attr[ATTR_INVISIBLE] = 1'b1;
            SGR_ITALIC_OFF:                 shadow_set.attr[ATTR_ITALIC]    = 1'b0;
            SGR_UNDER_OFF:                  shadow_set.attr[ATTR_UNDERLINE] = 1'b0;
            SGR_STRIKE_OFF:                 shadow_set.attr[ATTR_STRIKE]    = 1'b0;
            SGR_BLINK_OFF:                  shadow_set.attr[ATTR_BLINK]     = 1'b0;
            SGR_NEG_OFF:                    shadow_set.attr[ATTR_NEGATIVE]  = 1'b0;
            SGR_INVIS_OFF:                  shadow_set.attr[ATTR_INVISIBLE] = 1'b0;
            SGR_FG_DEFAULT: begin
               shadow_set.fg = dflt_fg;
               if (shadow_set.bright && shadow_set.fg < 4'd8) begin
                  shadow_set.fg = shadow_set.fg + 4'd8;
               end
            end
            SGR_BG_DEFAULT: shadow_set.bg = dflt_bg;
            default: ;
         endcase
      end
   endfunction

   // Advances the parser copy by one accepted item.
   function automatic void take_item(input logic op, input logic [7:0] b);
      int unsigned     acc;
      styled_byte_type due_item;
      if (op == OP_FLUSH) begin
         leave_escape();
         restore_defaults();
      end else if (!in_esc) begin
         if (b == BYTE_ESC) begin
            leave_escape();
            in_esc     = 1'b1;
            shadow_set = live_set;
         end else begin
            due_item.text = b;
            due_item.fg   = live_set.fg;
            due_item.bg   = live_set.bg;
            due_item.attr = live_set.attr;
            styled_due.push_back(due_item);
         end
      end else if (b >= BYTE_ZERO && b <= BYTE_NINE) begin
         // Parameter digits accumulate and stick at the top value.
         acc = num_active ? num_acc : 0;
         acc = acc * 10 + (b - BYTE_ZERO);
         if (acc > ACC_MAX) begin
            acc = ACC_MAX;
         end
         num_acc    = 8'(acc);
         num_active = 1'b1;
      end else begin
         // Any other byte closes a pending parameter.
         if (num_active) begin
            stage_sgr_code(num_acc);
            code_seen  = 1'b1;
            num_active = 1'b0;
            num_acc    = 8'd0;
         end
         if ((b >= BYTE_UC_A && b <= BYTE_UC_Z) || (b >= BYTE_LC_A && b <= BYTE_LC_Z)) begin
            if (b == BYTE_FINAL && ansi_on) begin
               if (!code_seen) begin
                  stage_sgr_code(SGR_RESET);
               end
               live_set = shadow_set;
            end
            leave_escape();
         end
      end
   endfunction

   function automatic void check_result();
      styled_byte_type want;
      if (styled_due.size() == 0) begin
         mark_failure($sformatf("unexpected result byte %02h fg %0d bg %0d attr %02h",
                                rsp_text_byte, rsp_fg_index, rsp_bg_index, rsp_attr_bits));
         return;
      end
      want = styled_due.pop_front();
      checked_count++;
      if (want.text !== rsp_text_byte || want.fg !== rsp_fg_index ||
          want.bg !== rsp_bg_index || want.attr !== rsp_attr_bits) begin
         mark_failure($sformatf({"result %0d: expected byte %02h fg %0d bg %0d attr %02h,",
                                 " got byte %02h fg %0d bg %0d attr %02h"},
                                checked_count, want.text, want.fg, want.bg, want.attr,
                                rsp_text_byte, rsp_fg_index, rsp_bg_index, rsp_attr_bits));
      end
   endfunction

   // Everything is sampled at the rising edge, results before new items.
   always @(posedge clock) begin
      if (reset) begin
         ansi_on        = RST_USE_ANSI;
         dflt_fg        = RST_DEFAULT_FG;
         dflt_bg        = RST_DEFAULT_BG;
         leave_escape();
         restore_defaults();
         styled_due.delete();
         fail_count     = 0;
         checked_count  = 0;
         leftovers_done = 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_USE_ANSI:   ansi_on = csr_wdata[0];
               CSR_DEFAULT_FG: dflt_fg = csr_wdata[3:0];
               CSR_DEFAULT_BG: dflt_bg = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            check_result();
         end
         if (req_valid && req_ready) begin
            take_item(req_op, req_in_byte);
         end
         // Predictions still waiting at the end never got their result.
         if (run_done && !leftovers_done) begin
            leftovers_done = 1'b1;
            if (styled_due.size() != 0) begin
               fail_count += styled_due.size();
               $display("MISMATCH: %0d expected results never arrived", styled_due.size());
            end
         end
      end
      pending = styled_due.size();
   end

endmodule

@@ tb/ansi_sgr_attribute_parser_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ansi_sgr_attribute_parser_top_tb
// Drives terminal byte streams into the SGR attribute parser: a short
// directed run, then phases of random well-formed and broken escape
// sequences, plain text and flushes under several register settings, with
// random gaps on the byte side and stalls on the result side. The checker
// beside the parser predicts and compares every styled byte.
// ----------------------------------------------------------------------------
module ansi_sgr_attribute_parser_top_tb;
   import asgr_pkg::*;

   localparam int unsigned ITEM_TARGET  = 1300;
   localparam int unsigned PHASE_COUNT  = 8;
   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam logic [7:0]  BYTE_CSI     = 8'h5B;   // '['
   localparam logic [7:0]  BYTE_SEP     = 8'h3B;   // ';'
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SLOW} rx_mode_type;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   logic                       req_op      = OP_BYTE;
   logic [7:0]                 req_in_byte = 8'd0;
   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   logic [7:0]                 rsp_text_byte;
   logic [3:0]                 rsp_fg_index;
   logic [3:0]                 rsp_bg_index;
   logic [5:0]                 rsp_attr_bits;
   logic                       csr_we      = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index   = CSR_USE_ANSI;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata   = '0;
   logic                       run_done    = 1'b0;

   int unsigned fail_count;
   int unsigned pending_results;
   int unsigned checked_count;
   int unsigned items_sent     = 0;
   int unsigned flush_count    = 0;
   int unsigned escape_count   = 0;
   int unsigned settings_count = 1;
   int unsigned burst_left     = 0;
   int unsigned idle_cycles    = 0;
   int unsigned rx_tick        = 0;
   logic        tx_quiet       = 1'b0;
   rx_mode_type rx_mode        = RX_RANDOM;

   ansi_sgr_attribute_parser_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_text_byte (rsp_text_byte),
      .rsp_fg_index  (rsp_fg_index),
      .rsp_bg_index  (rsp_bg_index),
      .rsp_attr_bits (rsp_attr_bits),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   asgr_stream_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_text_byte (rsp_text_byte),
      .rsp_fg_index  (rsp_fg_index),
      .rsp_bg_index  (rsp_bg_index),
      .rsp_attr_bits (rsp_attr_bits),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .run_done      (run_done),
      .fail_count    (fail_count),
      .pending       (pending_results),
      .checked_count (checked_count)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The result side stalls according to the current mode.
   always @(negedge clock) begin
      rx_tick <= rx_tick + 1;
      case (rx_mode)
         RX_OPEN:     rsp_ready <= 1'b1;
         RX_RANDOM:   rsp_ready <= ($urandom_range(0, 9) < 7);
         RX_PERIODIC: rsp_ready <= ((rx_tick % 13) >= 4);
         default:     rsp_ready <= ($urandom_range(0, 9) < 3);
      endcase
   end

   // Ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Offers one item; bursts of items are separated by random gaps.
   task automatic push_byte(input logic op, input logic [7:0] b);
      int unsigned gap;
      int unsigned r;
      @(negedge clock);
      if (burst_left == 0) begin
         r   = $urandom_range(0, 9);
         gap = (tx_quiet || r < 5) ? 0 : (r < 9) ? $urandom_range(1, 4) : $urandom_range(8, 30);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_op      <= op;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (op == OP_FLUSH) begin
         flush_count++;
      end
   endtask

   // Holds the byte side until every predicted result is out and the
   // pipeline has had time to finish bytes that give no result.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_byte(OP_BYTE, s[i]);
      end
   endtask

   function automatic logic [7:0] pick_letter();
      if ($urandom_range(0, 1) == 0) begin
         return 8'($urandom_range(BYTE_UC_A, BYTE_UC_Z));
      end
      return 8'($urandom_range(BYTE_LC_A, BYTE_LC_Z));
   endfunction

   // Mostly ';', sometimes ESC or another byte that is neither digit nor letter.
   function automatic logic [7:0] pick_separator();
      logic [7:0] b;
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 17) begin
         return BYTE_SEP;
      end
      if (r == 17) begin
         return BYTE_ESC;
      end
      b = 8'($urandom_range(0, 255));
      while ((b >= BYTE_ZERO && b <= BYTE_NINE) || (b >= BYTE_UC_A && b <= BYTE_UC_Z) ||
             (b >= BYTE_LC_A && b <= BYTE_LC_Z)) begin
         b = 8'($urandom_range(0, 255));
      end
      return b;
   endfunction

   function automatic logic [7:0] pick_known_code();
      case ($urandom_range(0, 26))
         0:  return SGR_RESET;
         1:  return SGR_BRIGHT;
         2:  return SGR_DIM;
         3:  return SGR_ITALIC;
         4:  return SGR_UNDERLINE;
         5:  return SGR_BLINK_SLOW;
         6:  return SGR_BLINK_FAST;
         7:  return SGR_NEGATIVE;
         8:  return SGR_INVISIBLE;
         9:  return SGR_STRIKE;
         10: return SGR_ITALIC_ALT;
         11: return SGR_UNDER_ALT;
         12: return SGR_NORMAL;
         13: return SGR_ITALIC_OFF;
         14: return SGR_UNDER_OFF;
         15: return SGR_BLINK_OFF;
         16: return SGR_NEG_OFF;
         17: return SGR_INVIS_OFF;
         18: return SGR_STRIKE_OFF;
         19: return SGR_FG_DEFAULT;
         20: return SGR_BG_DEFAULT;
         21, 22, 23: return SGR_FG_FIRST + 8'($urandom_range(0, 7));
         default:    return SGR_BG_FIRST + 8'($urandom_range(0, 7));
      endcase
   endfunction

   // Known codes, other small numbers, and values past the saturation point.
   task automatic send_parameter();
      int unsigned r;
      int unsigned value;
      string       digits;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         value = pick_known_code();
      end else if (r < 92) begin
         value = $urandom_range(0, 99);
      end else begin
         value = $urandom_range(256, 99999);
      end
      digits = $sformatf("%0d", value);
      if ($urandom_range(0, 9) == 0) begin
         digits = {"0", digits};
      end
      send_string(digits);
   endtask

   // ESC, optional '[', a few parameters, then mostly 'm' as the final letter.
   task automatic send_sgr_sequence();
      int unsigned count;
      escape_count++;
      push_byte(OP_BYTE, BYTE_ESC);
      if ($urandom_range(0, 4) != 0) begin
         push_byte(OP_BYTE, BYTE_CSI);
      end
      count = $urandom_range(0, 4);
      for (int i = 0; i < count; i++) begin
         if (i > 0) begin
            push_byte(OP_BYTE, pick_separator());
         end
         if ($urandom_range(0, 19) != 0) begin
            send_parameter();
         end
      end
      push_byte(OP_BYTE, ($urandom_range(0, 6) != 0) ? BYTE_FINAL : pick_letter());
   endtask

   task automatic send_text(input int unsigned count);
      logic [7:0] b;
      for (int i = 0; i < count; i++) begin
         b = 8'($urandom_range(0, 255));
         if (b == BYTE_ESC) begin
            b = ~b;
         end
         push_byte(OP_BYTE, b);
      end
   endtask

   task automatic send_random_segment();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         send_sgr_sequence();
         send_text($urandom_range(1, 6));
      end else if (r < 75) begin
         send_text($urandom_range(1, 8));
      end else if (r < 85) begin
         push_byte(OP_FLUSH, 8'($urandom_range(0, 255)));
      end else if (r < 95) begin
         // Broken sequence: ESC followed by arbitrary bytes.
         escape_count++;
         push_byte(OP_BYTE, BYTE_ESC);
         repeat ($urandom_range(1, 6)) push_byte(OP_BYTE, 8'($urandom_range(0, 255)));
      end else begin
         push_byte(OP_BYTE, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int unsigned phase_end;
      logic        ansi_cfg;
      logic [3:0]  fg_cfg;
      logic [3:0]  bg_cfg;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: byte extremes, bright with a color, a saturated parameter
      // under a non-'m' final, an empty list, ESC inside a sequence and a
      // flush while a sequence is open.
      push_byte(OP_BYTE, 8'h00);
      push_byte(OP_BYTE, 8'hFF);
      push_byte(OP_BYTE, BYTE_ESC);
      send_string("[1;31ma");
      push_byte(OP_BYTE, BYTE_ESC);
      send_string("999;7kb");
      push_byte(OP_BYTE, BYTE_ESC);
      push_byte(OP_BYTE, BYTE_FINAL);
      send_string("c");
      push_byte(OP_BYTE, BYTE_ESC);
      send_string("[5");
      push_byte(OP_BYTE, BYTE_ESC);
      send_string("9md");
      push_byte(OP_BYTE, BYTE_ESC);
      send_string("[3");
      push_byte(OP_FLUSH, 8'hA5);
      send_string("e");
      escape_count += 5;

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         settle();
         ansi_cfg = !(phase == 2 || phase == 5);
         fg_cfg   = (phase == 0) ? 4'd0 : (phase == 1) ? 4'd15 : 4'($urandom_range(0, 15));
         bg_cfg   = (phase == 0) ? 4'd15 : (phase == 1) ? 4'd0 : 4'($urandom_range(0, 15));
         write_csr(CSR_USE_ANSI, {3'($urandom_range(0, 7)), ansi_cfg});
         write_csr(CSR_DEFAULT_FG, fg_cfg);
         write_csr(CSR_DEFAULT_BG, bg_cfg);
         if (phase == 3) begin
            write_csr(CSR_SPARE, 4'($urandom_range(0, 15)));
         end
         settings_count++;
         tx_quiet  = (phase == 4);
         rx_mode   = (phase == 4) ? RX_OPEN : rx_mode_type'(phase % 4);
         phase_end = items_sent + ITEM_TARGET / PHASE_COUNT;
         while (items_sent < phase_end) begin
            send_random_segment();
         end
      end

      settle();
      repeat (8) @(negedge clock);
      run_done <= 1'b1;
      repeat (2) @(negedge clock);
      $display("Sent %0d items (%0d flushes, %0d escape sequences) under %0d register settings;",
               items_sent, flush_count, escape_count, settings_count);
      $display("checked %0d styled bytes against the prediction.", checked_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
